[hdl/ntss_pkg.sv]
package ntss_pkg;

    localparam int POS_W    = 10;
    localparam int POS_SPAN = 1 << POS_W;
    localparam int CNT_W    = 16;
    localparam int PEND_W   = 24;
    localparam int SUM_W    = 32;
    localparam int WORD_W   = 32;
    localparam int BIT_W    = 5;
    localparam int ROW_W    = POS_W - BIT_W;

    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [PEND_W-1:0] PEND_MAX = {PEND_W{1'b1}};
    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_SERVE = 1'b1;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_ADD    = 11'b000_0000_0010,
        S_SCAN   = 11'b000_0000_0100,
        S_RSCAN  = 11'b000_0000_1000,
        S_LSUM   = 11'b000_0001_0000,
        S_LROW   = 11'b000_0010_0000,
        S_RSUM   = 11'b000_0100_0000,
        S_RROW   = 11'b000_1000_0000,
        S_DECIDE = 11'b001_0000_0000,
        S_TAKE   = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } t_state;

    typedef struct packed {
        logic [WORD_W-1:0] vec;
        logic              find_high;
    } t_find_req;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] idx;
    } t_find_rsp;

endpackage

[hdl/ntss_ram.sv]
module ntss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[hdl/ntss_find.sv]
module ntss_find (
    input  ntss_pkg::t_find_req i_req,
    output ntss_pkg::t_find_rsp o_rsp
);

    // priority pick: the last hit in loop order wins
    always_comb begin
        o_rsp = '0;
        if (i_req.find_high) begin
            for (int i = 0; i < ntss_pkg::WORD_W; i++) begin
                if (i_req.vec[i]) begin
                    o_rsp.found = 1'b1;
                    o_rsp.idx   = ntss_pkg::BIT_W'(i);
                end
            end
        end else begin
            for (int i = ntss_pkg::WORD_W - 1; i >= 0; i--) begin
                if (i_req.vec[i]) begin
                    o_rsp.found = 1'b1;
                    o_rsp.idx   = ntss_pkg::BIT_W'(i);
                end
            end
        end
    end

endmodule

[hdl/nearest_target_seek_scheduler.sv]
// Channel   Direction  Handshake         Payload
// command   in         start & !busy     i_cmd, i_position
// result    out        o_done (1 cycle)  o_served, o_head_position, o_moved_distance,
//                                        o_total_distance, o_facing_left
//
// Busy after accept: add S_ADD, S_DONE; dropped add S_DONE; serve at the head S_SCAN, S_DONE;
// empty serve S_DONE; serve with a move S_SCAN to S_DONE, S_LROW and S_RROW as needed.
// The moving serve walks one priority finder over the head row, the row summary
// and up to two fetched rows, each fetch through the single bitmap read port.
// Reset is synchronous; counts need no clearing since a clear bitmap bit marks
// its count as zero. Results go out without stall; one item per result.
module nearest_target_seek_scheduler #(
    parameter int NUM_POSITIONS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cmd,
    input  logic [ntss_pkg::POS_W-1:0]    i_position,
    output logic                          o_done,
    output logic                          o_served,
    output logic [ntss_pkg::POS_W-1:0]    o_head_position,
    output logic [ntss_pkg::POS_W-1:0]    o_moved_distance,
    output logic [ntss_pkg::SUM_W-1:0]    o_total_distance,
    output logic                          o_facing_left
);

    localparam int DEPTH = (NUM_POSITIONS < ntss_pkg::POS_SPAN) ?
                           NUM_POSITIONS : ntss_pkg::POS_SPAN;
    localparam int CAW   = $clog2(DEPTH);
    localparam int ROWS  = (DEPTH + ntss_pkg::WORD_W - 1) / ntss_pkg::WORD_W;
    localparam int BAW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [ntss_pkg::POS_W:0] DEPTH_V = (ntss_pkg::POS_W + 1)'(DEPTH);

    ntss_pkg::t_state r_state, n_state;

    logic [ntss_pkg::POS_W-1:0]  r_pos, r_head, r_lpos, r_rpos, r_dest, r_moved;
    logic                        r_left, r_lok, r_rok, r_served;
    logic [ntss_pkg::PEND_W-1:0] r_pending;
    logic [ntss_pkg::SUM_W-1:0]  r_sum;
    logic [ntss_pkg::WORD_W-1:0] r_nz, r_word, r_lword, r_rword, r_dword;

    logic                        accept, in_range;
    logic [ntss_pkg::ROW_W-1:0]  hr;
    logic [ntss_pkg::BIT_W-1:0]  hb;
    logic [ntss_pkg::WORD_W-1:0] bit_lo_mask, bit_hi_mask, row_lo_mask, row_hi_mask;
    logic [ntss_pkg::WORD_W-1:0] head_word, add_word, t_word, t_newword;
    logic [ntss_pkg::CNT_W-1:0]  add_cnt, t_newcnt;
    logic [ntss_pkg::POS_W-1:0]  t_pos;
    logic [ntss_pkg::POS_W-1:0]  dl, dr, d_dest, d_moved;
    logic                        tie, go_left, any_side;
    logic [ntss_pkg::SUM_W:0]    sum_ext;

    logic                        cnt_we, bm_we;
    logic [CAW-1:0]              cnt_waddr, cnt_raddr;
    logic [ntss_pkg::CNT_W-1:0]  cnt_wdata, cnt_rdata;
    logic [BAW-1:0]              bm_waddr, bm_raddr;
    logic [ntss_pkg::WORD_W-1:0] bm_wdata, bm_rdata;

    ntss_pkg::t_find_req fq;
    ntss_pkg::t_find_rsp fr;

    ntss_ram #(.WIDTH(ntss_pkg::CNT_W), .DEPTH(DEPTH), .AW(CAW)) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    ntss_ram #(.WIDTH(ntss_pkg::WORD_W), .DEPTH(ROWS), .AW(BAW)) u_bitmap_ram (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_raddr (bm_raddr),
        .o_rdata (bm_rdata)
    );

    ntss_find u_find (
        .i_req (fq),
        .o_rsp (fr)
    );

    assign accept   = start && !busy;
    assign in_range = {1'b0, i_position} < DEPTH_V;
    assign hr       = r_head[ntss_pkg::POS_W-1:ntss_pkg::BIT_W];
    assign hb       = r_head[ntss_pkg::BIT_W-1:0];

    assign bit_lo_mask = (ntss_pkg::WORD_W'(1) << hb) - ntss_pkg::WORD_W'(1);
    assign bit_hi_mask = ~(bit_lo_mask | (ntss_pkg::WORD_W'(1) << hb));
    assign row_lo_mask = (ntss_pkg::WORD_W'(1) << hr) - ntss_pkg::WORD_W'(1);
    assign row_hi_mask = ~(row_lo_mask | (ntss_pkg::WORD_W'(1) << hr));

    // a row whose summary bit is clear holds nothing, whatever the RAM says
    assign head_word = r_nz[hr] ? bm_rdata : '0;
    assign add_word  = r_nz[r_pos[ntss_pkg::POS_W-1:ntss_pkg::BIT_W]] ? bm_rdata : '0;
    assign add_cnt   = add_word[r_pos[ntss_pkg::BIT_W-1:0]] ? cnt_rdata : '0;

    // take one target: at the head during scan, at the chosen side otherwise
    assign t_pos     = (r_state == ntss_pkg::S_SCAN) ? r_head : r_dest;
    assign t_word    = (r_state == ntss_pkg::S_SCAN) ? head_word : r_dword;
    assign t_newcnt  = cnt_rdata - ntss_pkg::CNT_W'(1);
    assign t_newword = (t_newcnt == '0) ?
                       (t_word & ~(ntss_pkg::WORD_W'(1) << t_pos[ntss_pkg::BIT_W-1:0])) :
                       t_word;

    assign dl       = r_head - r_lpos;
    assign dr       = r_rpos - r_head;
    assign tie      = r_lok && r_rok && (dl == dr);
    assign go_left  = tie ? r_left : (r_lok && (!r_rok || dl < dr));
    assign any_side = r_lok || r_rok;
    assign d_dest   = go_left ? r_lpos : r_rpos;
    assign d_moved  = go_left ? dl : dr;
    assign sum_ext  = {1'b0, r_sum} + (ntss_pkg::SUM_W + 1)'(d_moved);

    always_comb begin
        fq = '0;
        case (r_state)
            ntss_pkg::S_SCAN: begin
                fq.vec       = head_word & bit_lo_mask;
                fq.find_high = 1'b1;
            end
            ntss_pkg::S_RSCAN: begin
                fq.vec       = r_word & bit_hi_mask;
                fq.find_high = 1'b0;
            end
            ntss_pkg::S_LSUM: begin
                fq.vec       = r_nz & row_lo_mask;
                fq.find_high = 1'b1;
            end
            ntss_pkg::S_LROW: begin
                fq.vec       = bm_rdata;
                fq.find_high = 1'b1;
            end
            ntss_pkg::S_RSUM: begin
                fq.vec       = r_nz & row_hi_mask;
                fq.find_high = 1'b0;
            end
            ntss_pkg::S_RROW: begin
                fq.vec       = bm_rdata;
                fq.find_high = 1'b0;
            end
            default: begin
                fq = '0;
            end
        endcase
    end

    always_comb begin
        cnt_raddr = CAW'(r_head);
        bm_raddr  = BAW'(hr);
        cnt_we    = 1'b0;
        cnt_waddr = CAW'(t_pos);
        cnt_wdata = t_newcnt;
        bm_we     = 1'b0;
        bm_waddr  = BAW'(t_pos[ntss_pkg::POS_W-1:ntss_pkg::BIT_W]);
        bm_wdata  = t_newword;
        case (r_state)
            ntss_pkg::S_IDLE: begin
                if (i_cmd == ntss_pkg::CMD_ADD) begin
                    cnt_raddr = CAW'(i_position);
                    bm_raddr  = BAW'(i_position[ntss_pkg::POS_W-1:ntss_pkg::BIT_W]);
                end
            end
            ntss_pkg::S_ADD: begin
                cnt_we    = add_cnt != ntss_pkg::CNT_MAX;
                cnt_waddr = CAW'(r_pos);
                cnt_wdata = add_cnt + ntss_pkg::CNT_W'(1);
                bm_we     = add_cnt != ntss_pkg::CNT_MAX;
                bm_waddr  = BAW'(r_pos[ntss_pkg::POS_W-1:ntss_pkg::BIT_W]);
                bm_wdata  = add_word | (ntss_pkg::WORD_W'(1) << r_pos[ntss_pkg::BIT_W-1:0]);
            end
            ntss_pkg::S_SCAN: begin
                cnt_we = head_word[hb];
                bm_we  = head_word[hb];
            end
            ntss_pkg::S_LSUM, ntss_pkg::S_RSUM: begin
                bm_raddr = BAW'(fr.idx);
            end
            ntss_pkg::S_DECIDE: begin
                cnt_raddr = CAW'(d_dest);
            end
            ntss_pkg::S_TAKE: begin
                cnt_we = 1'b1;
                bm_we  = 1'b1;
            end
            default: begin
                cnt_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ntss_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_cmd == ntss_pkg::CMD_ADD) begin
                        n_state = (in_range && r_pending != ntss_pkg::PEND_MAX) ?
                                  ntss_pkg::S_ADD : ntss_pkg::S_DONE;
                    end else begin
                        n_state = (r_pending != '0) ? ntss_pkg::S_SCAN : ntss_pkg::S_DONE;
                    end
                end
            end
            ntss_pkg::S_ADD:   n_state = ntss_pkg::S_DONE;
            ntss_pkg::S_SCAN:  n_state = head_word[hb] ? ntss_pkg::S_DONE : ntss_pkg::S_RSCAN;
            ntss_pkg::S_RSCAN: n_state = ntss_pkg::S_LSUM;
            ntss_pkg::S_LSUM: begin
                n_state = (!r_lok && fr.found) ? ntss_pkg::S_LROW : ntss_pkg::S_RSUM;
            end
            ntss_pkg::S_LROW:  n_state = ntss_pkg::S_RSUM;
            ntss_pkg::S_RSUM: begin
                n_state = (!r_rok && fr.found) ? ntss_pkg::S_RROW : ntss_pkg::S_DECIDE;
            end
            ntss_pkg::S_RROW:  n_state = ntss_pkg::S_DECIDE;
            ntss_pkg::S_DECIDE: n_state = any_side ? ntss_pkg::S_TAKE : ntss_pkg::S_DONE;
            ntss_pkg::S_TAKE:  n_state = ntss_pkg::S_DONE;
            ntss_pkg::S_DONE:  n_state = ntss_pkg::S_IDLE;
            default:           n_state = ntss_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ntss_pkg::S_IDLE;
            r_head    <= '0;
            r_left    <= 1'b0;
            r_pending <= '0;
            r_sum     <= '0;
            r_nz      <= '0;
            r_served  <= 1'b0;
            r_moved   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ntss_pkg::S_IDLE: begin
                    if (accept) begin
                        r_served <= 1'b0;
                        r_moved  <= '0;
                    end
                end
                ntss_pkg::S_ADD: begin
                    if (add_cnt != ntss_pkg::CNT_MAX) begin
                        r_nz[r_pos[ntss_pkg::POS_W-1:ntss_pkg::BIT_W]] <= 1'b1;
                        r_pending <= r_pending + ntss_pkg::PEND_W'(1);
                    end
                end
                ntss_pkg::S_SCAN: begin
                    if (head_word[hb]) begin
                        r_nz[hr]  <= |t_newword;
                        r_pending <= r_pending - ntss_pkg::PEND_W'(1);
                        r_served  <= 1'b1;
                    end
                end
                ntss_pkg::S_DECIDE: begin
                    if (any_side) begin
                        r_left <= go_left;
                        r_head <= d_dest;
                        r_moved <= d_moved;
                        r_sum  <= sum_ext[ntss_pkg::SUM_W] ? ntss_pkg::SUM_MAX :
                                  sum_ext[ntss_pkg::SUM_W-1:0];
                    end
                end
                ntss_pkg::S_TAKE: begin
                    r_nz[r_dest[ntss_pkg::POS_W-1:ntss_pkg::BIT_W]] <= |t_newword;
                    r_pending <= r_pending - ntss_pkg::PEND_W'(1);
                    r_served  <= 1'b1;
                end
                default: begin
                    r_served <= r_served;
                end
            endcase
        end
    end

    // search bookkeeping, no reset needed
    always_ff @(posedge i_clk) begin
        case (r_state)
            ntss_pkg::S_IDLE: begin
                if (accept) begin
                    r_pos <= i_position;
                end
            end
            ntss_pkg::S_SCAN: begin
                r_word  <= head_word;
                r_lword <= head_word;
                r_rword <= head_word;
                r_lok   <= fr.found;
                r_lpos  <= {hr, fr.idx};
            end
            ntss_pkg::S_RSCAN: begin
                r_rok  <= fr.found;
                r_rpos <= {hr, fr.idx};
            end
            ntss_pkg::S_LSUM: begin
                if (!r_lok) begin
                    r_lpos[ntss_pkg::POS_W-1:ntss_pkg::BIT_W] <= fr.idx;
                end
            end
            ntss_pkg::S_LROW: begin
                r_lok   <= fr.found;
                r_lpos[ntss_pkg::BIT_W-1:0] <= fr.idx;
                r_lword <= bm_rdata;
            end
            ntss_pkg::S_RSUM: begin
                if (!r_rok) begin
                    r_rpos[ntss_pkg::POS_W-1:ntss_pkg::BIT_W] <= fr.idx;
                end
            end
            ntss_pkg::S_RROW: begin
                r_rok   <= fr.found;
                r_rpos[ntss_pkg::BIT_W-1:0] <= fr.idx;
                r_rword <= bm_rdata;
            end
            ntss_pkg::S_DECIDE: begin
                r_dest  <= d_dest;
                r_dword <= go_left ? r_lword : r_rword;
            end
            default: begin
                r_dest <= r_dest;
            end
        endcase
    end

    assign busy             = r_state != ntss_pkg::S_IDLE;
    assign o_done           = r_state == ntss_pkg::S_DONE;
    assign o_served         = r_served;
    assign o_head_position  = r_head;
    assign o_moved_distance = r_moved;
    assign o_total_distance = r_sum;
    assign o_facing_left    = r_left;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted item did not raise busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_move_served: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_moved_distance != '0) |-> o_served)
        else $error("head moved without serving a target");

    a_empty_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending == '0) |-> (r_nz == '0))
        else $error("row summary set with nothing pending");

endmodule
